### src/tws_pkg.sv
`timescale 1ns / 1ps
// Package for the topological wave scheduler.
// Request/response payload structs, request codes and sizing constants.
package tws_pkg;

	localparam int NUM_MODULES = 16;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 5;
	localparam int WAVE_W      = 4;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_RUN   = 2'd2,
		REQ_NONE  = 2'd3
	} req_code_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] src_module;
		logic [IDX_W-1:0] dest_module;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  module_index;
		logic [WAVE_W-1:0] wave;
		logic              cycle_error;
		logic              last;
	} rsp_t;

endpackage

### src/topological_wave_scheduler_core.sv
`timescale 1ns / 1ps
// Topological wave scheduler: predecessor masks in a 16x16 synchronous RAM.
// Depends on tws_pkg.
// Clear request: valid bits cleared. Add-edge request: read, then write back.
// Run request: each wave scans the RAM, then emits one response per ready
// module per cycle while rsp_stall is low; request input stalls meanwhile.
// A wave with no ready module gives one response with cycle_error and last set.
// Reset: masks read as zero (per-entry valid bits cleared), module count 16.
module topological_wave_scheduler_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  tws_pkg::req_t           req,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output tws_pkg::rsp_t           rsp,
	input  logic                    cfg_we,
	input  logic [tws_pkg::CNT_W-1:0] cfg_data
);
	import tws_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADD  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        n_eff;
	logic [NUM_MODULES:0]    all_w;
	logic [NUM_MODULES-1:0]  all_mask;

	logic [NUM_MODULES-1:0]  mem [NUM_MODULES];
	logic [NUM_MODULES-1:0]  rdata_s1;
	logic [NUM_MODULES-1:0]  valid_q;
	logic [IDX_W-1:0]        raddr;
	logic                    mem_we;
	logic [NUM_MODULES-1:0]  wdata;

	logic [IDX_W-1:0]        src_s1;
	logic [IDX_W-1:0]        dst_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    rd_vld_s1;

	logic [CNT_W-1:0]        scan_q;
	logic [NUM_MODULES-1:0]  ready_q;
	logic [NUM_MODULES-1:0]  done_q;
	logic [WAVE_W-1:0]       wave_q;

	logic                    accept;
	logic                    slot_free;
	logic [NUM_MODULES-1:0]  mask_eff;
	logic                    is_ready;
	logic [NUM_MODULES-1:0]  ready_nxt;
	logic [IDX_W-1:0]        pick;
	logic [NUM_MODULES-1:0]  pick_bit;
	logic [NUM_MODULES-1:0]  ready_left;
	logic [NUM_MODULES-1:0]  done_nxt;

	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(NUM_MODULES)) begin
			n_eff = CNT_W'(NUM_MODULES);
		end else begin
			n_eff = count_q;
		end
	end

	assign all_w    = ((NUM_MODULES+1)'(1) << n_eff) - (NUM_MODULES+1)'(1);
	assign all_mask = all_w[NUM_MODULES-1:0];

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_free = !rsp_valid || !rsp_stall;

	assign raddr  = (state_q == ST_IDLE) ? req.dest_module : scan_q[IDX_W-1:0];
	assign mem_we = (state_q == ST_ADD);
	assign wdata  = (valid_q[dst_s1] ? rdata_s1 : '0) | (NUM_MODULES'(1) << src_s1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[dst_s1] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// scan evaluation of the entry read last cycle
	assign mask_eff  = valid_q[idx_s1] ? rdata_s1 : '0;
	assign is_ready  = ((mask_eff & all_mask & ~done_q) == '0) && !done_q[idx_s1];
	assign ready_nxt = (rd_vld_s1 && is_ready) ?
		(ready_q | (NUM_MODULES'(1) << idx_s1)) : ready_q;

	always_comb begin
		pick = '0;
		for (int i = NUM_MODULES - 1; i >= 0; i--) begin
			if (ready_q[i]) begin
				pick = IDX_W'(i);
			end
		end
	end

	assign pick_bit   = NUM_MODULES'(1) << pick;
	assign ready_left = ready_q & ~pick_bit;
	assign done_nxt   = done_q | pick_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= CNT_W'(NUM_MODULES);
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			rsp_valid <= 1'b0;
			scan_q    <= '0;
			ready_q   <= '0;
			done_q    <= '0;
			wave_q    <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (slot_free) begin
				rsp_valid <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_CLEAR: valid_q <= '0;
							REQ_ADD: begin
								if ({1'b0, req.src_module} < n_eff &&
								    {1'b0, req.dest_module} < n_eff) begin
									state_q <= ST_ADD;
								end
							end
							REQ_RUN: begin
								done_q  <= '0;
								wave_q  <= '0;
								ready_q <= '0;
								scan_q  <= '0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_ADD: begin
					valid_q[dst_s1] <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_SCAN: begin
					ready_q <= ready_nxt;
					if (scan_q < n_eff) begin
						rd_vld_s1 <= 1'b1;
						scan_q    <= scan_q + CNT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						rsp_valid <= 1'b1;
						if (ready_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							ready_q <= ready_left;
							done_q  <= done_nxt;
							if (ready_left == '0) begin
								if (done_nxt == all_mask) begin
									state_q <= ST_IDLE;
								end else begin
									wave_q  <= wave_q + WAVE_W'(1);
									scan_q  <= '0;
									state_q <= ST_SCAN;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pipeline and payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			src_s1 <= req.src_module;
			dst_s1 <= req.dest_module;
		end
		idx_s1 <= scan_q[IDX_W-1:0];
		if (state_q == ST_EMIT && slot_free) begin
			if (ready_q == '0) begin
				rsp.module_index <= '0;
				rsp.wave         <= wave_q;
				rsp.cycle_error  <= 1'b1;
				rsp.last         <= 1'b1;
			end else begin
				rsp.module_index <= pick;
				rsp.wave         <= wave_q;
				rsp.cycle_error  <= 1'b0;
				rsp.last         <= (ready_left == '0) && (done_nxt == all_mask);
			end
		end
	end

endmodule
